// ===== src/mjp_pkg.sv =====
package mjp_pkg;

    localparam int MAX_JETS      = 16;
    localparam int MOMENTUM_BITS = 20;

    localparam int EW  = MOMENTUM_BITS - 1;               // stored energy width
    localparam int PW  = MOMENTUM_BITS;                   // stored momentum width
    localparam int SW  = PW + $clog2(MAX_JETS);           // group sum width
    localparam int MW  = 2 * SW + 3;                      // mass sum width
    localparam int CW  = $clog2(MAX_JETS + 1);            // jet count width
    localparam int IW  = (MAX_JETS > 2) ? $clog2(MAX_JETS) : 1;
    localparam int DRAIN_CYC = 5;                         // eval pipe depth to best regs
    localparam int DW  = $clog2(DRAIN_CYC);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SINGLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                load;   // input transfer this cycle
        logic                clr;    // clear group A and search pipe
        logic                eval;   // evaluate a split this cycle
        logic                upd;    // move one jet in or out of group A
        logic                add;
        logic [IW-1:0]       idx;
        logic [MAX_JETS-1:0] mask;
        logic                all;    // mask is the opening candidate: every jet but jet 0
        logic                emit;   // result strobe, end of event
    } t_cmd;

    typedef struct packed {
        logic [CW-1:0] count;
    } t_stat;

    function automatic logic [23:0] fit_sum(input logic signed [SW-1:0] s);
        logic signed [SW+23:0] t;
        t = (SW + 24)'(s);
        return t[23:0];
    endfunction

    function automatic logic [50:0] fit_mass(input logic signed [MW-1:0] s);
        logic signed [MW+50:0] t;
        t = (MW + 51)'(s);
        return t[50:0];
    endfunction

    function automatic logic [15:0] fit_mask(input logic [MAX_JETS-1:0] m);
        logic [MAX_JETS+15:0] t;
        t = (MAX_JETS + 16)'(m);
        return t[15:0];
    endfunction

endpackage

// ===== src/mjp_ctrl.sv =====
module mjp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last_jet,
    input  mjp_pkg::t_stat i_stat,
    output mjp_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    mjp_pkg::t_state                r_state, n_state;
    logic [mjp_pkg::MAX_JETS-1:0]   r_k, n_k;
    logic [mjp_pkg::DW-1:0]         r_d, n_d;

    logic [mjp_pkg::MAX_JETS:0]     w_pow;
    logic [mjp_pkg::MAX_JETS-1:0]   w_all;
    logic [mjp_pkg::MAX_JETS-1:0]   w_gray;
    logic [mjp_pkg::IW-1:0]         w_tz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mjp_pkg::ST_IDLE;
            r_k     <= '0;
            r_d     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_d     <= n_d;
        end
    end

    always_comb begin
        w_pow  = (mjp_pkg::MAX_JETS + 1)'(1) << i_stat.count;
        w_all  = mjp_pkg::MAX_JETS'(w_pow - 1'b1);
        w_gray = r_k ^ (r_k >> 1);
        // bit that flips in the Gray walk: lowest set bit of the step count
        w_tz = '0;
        for (int j = mjp_pkg::MAX_JETS - 1; j >= 0; j--) begin
            if (r_k[j]) w_tz = mjp_pkg::IW'(j);
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_d     = r_d;
        o_cmd   = '0;
        unique case (r_state)
            mjp_pkg::ST_IDLE: begin
                o_cmd.load = i_start;
                if (i_start && i_last_jet) n_state = mjp_pkg::ST_INIT;
            end
            mjp_pkg::ST_INIT: begin
                o_cmd.clr = 1'b1;
                n_k       = mjp_pkg::MAX_JETS'(1);
                n_state   = (i_stat.count < mjp_pkg::CW'(2)) ? mjp_pkg::ST_SINGLE
                                                             : mjp_pkg::ST_WALK;
            end
            mjp_pkg::ST_SINGLE: begin
                o_cmd.eval = 1'b1;
                n_d        = '0;
                n_state    = mjp_pkg::ST_DRAIN;
            end
            mjp_pkg::ST_WALK: begin
                // all jets in group A is stepped through but never scored
                o_cmd.eval = (w_gray != w_all);
                o_cmd.upd  = 1'b1;
                o_cmd.idx  = w_tz;
                o_cmd.add  = w_gray[w_tz];
                o_cmd.mask = w_gray;
                o_cmd.all  = (w_gray == (w_all - 1'b1));
                n_k        = r_k + 1'b1;
                if (r_k == w_all) begin
                    n_d     = '0;
                    n_state = mjp_pkg::ST_DRAIN;
                end
            end
            mjp_pkg::ST_DRAIN: begin
                n_d = r_d + 1'b1;
                if (r_d == mjp_pkg::DW'(mjp_pkg::DRAIN_CYC - 1)) n_state = mjp_pkg::ST_DONE;
            end
            mjp_pkg::ST_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = mjp_pkg::ST_IDLE;
            end
            default: n_state = mjp_pkg::ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != mjp_pkg::ST_IDLE);

endmodule

// ===== src/mjp_dpath.sv =====
module mjp_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mjp_pkg::t_cmd       i_cmd,
    input  logic [18:0]         i_energy,
    input  logic signed [19:0]  i_mom_x,
    input  logic signed [19:0]  i_mom_y,
    input  logic signed [19:0]  i_mom_z,
    input  logic                i_has_jet,
    output mjp_pkg::t_stat      o_stat,
    output logic [15:0]         o_group_mask,
    output logic [50:0]         o_min_mass_sum,
    output logic [23:0]         o_sum_a_energy,
    output logic [23:0]         o_sum_a_x,
    output logic [23:0]         o_sum_a_y,
    output logic [23:0]         o_sum_a_z,
    output logic [23:0]         o_sum_b_energy,
    output logic [23:0]         o_sum_b_x,
    output logic [23:0]         o_sum_b_y,
    output logic [23:0]         o_sum_b_z,
    output logic [4:0]          o_jet_count,
    output logic                o_dropped
);

    localparam int MJ = mjp_pkg::MAX_JETS;
    localparam int SW = mjp_pkg::SW;
    localparam int MW = mjp_pkg::MW;

    // jet store
    logic [mjp_pkg::EW-1:0]        r_se [MJ];
    logic signed [mjp_pkg::PW-1:0] r_sx [MJ];
    logic signed [mjp_pkg::PW-1:0] r_sy [MJ];
    logic signed [mjp_pkg::PW-1:0] r_sz [MJ];
    logic [mjp_pkg::CW-1:0]        r_count;
    logic                          r_ovf;
    logic signed [SW-1:0]          r_t [4];     // total of all kept jets
    logic signed [SW-1:0]          w_in [4];
    logic signed [SW-1:0]          w_j [4];
    logic                          w_store;

    // search pipe
    logic signed [SW-1:0]     r_a1 [4], r_a2 [4], r_b2 [4], r_a3 [4], r_b3 [4];
    logic signed [SW-1:0]     r_a4 [4], r_b4 [4], r_a5 [4], r_b5 [4];
    logic signed [2*SW-1:0]   r_pa [4], r_pb [4];
    logic signed [MW-1:0]     r_ma, r_mb, r_v;
    logic [MJ-1:0]            r_m1, r_m2, r_m3, r_m4, r_m5;
    logic                     r_all1, r_all2, r_all3, r_all4, r_all5;
    logic                     r_v1, r_v2, r_v3, r_v4, r_v5;

    // best split
    logic signed [MW-1:0]     r_bv;
    logic [MJ-1:0]            r_bm;
    logic                     r_ball, r_bvld;
    logic signed [SW-1:0]     r_ba [4], r_bb [4];
    logic                     w_better;

    assign w_store = i_cmd.load && i_has_jet && (r_count < mjp_pkg::CW'(MJ));

    always_comb begin
        w_in[0] = signed'(SW'(mjp_pkg::EW'(i_energy)));
        w_in[1] = SW'(mjp_pkg::PW'(i_mom_x));
        w_in[2] = SW'(mjp_pkg::PW'(i_mom_y));
        w_in[3] = SW'(mjp_pkg::PW'(i_mom_z));
        w_j[0]  = signed'(SW'(r_se[i_cmd.idx]));
        w_j[1]  = SW'(r_sx[i_cmd.idx]);
        w_j[2]  = SW'(r_sy[i_cmd.idx]);
        w_j[3]  = SW'(r_sz[i_cmd.idx]);
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_se[r_count[mjp_pkg::IW-1:0]] <= mjp_pkg::EW'(i_energy);
            r_sx[r_count[mjp_pkg::IW-1:0]] <= mjp_pkg::PW'(i_mom_x);
            r_sy[r_count[mjp_pkg::IW-1:0]] <= mjp_pkg::PW'(i_mom_y);
            r_sz[r_count[mjp_pkg::IW-1:0]] <= mjp_pkg::PW'(i_mom_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            for (int c = 0; c < 4; c++) r_t[c] <= '0;
        end else if (i_cmd.load && i_has_jet) begin
            if (w_store) begin
                r_count <= r_count + 1'b1;
                for (int c = 0; c < 4; c++) r_t[c] <= r_t[c] + w_in[c];
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // stage 1: group A sums follow the Gray walk, one jet per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            for (int c = 0; c < 4; c++) r_a1[c] <= '0;
        end else if (i_cmd.upd) begin
            for (int c = 0; c < 4; c++)
                r_a1[c] <= i_cmd.add ? r_a1[c] + w_j[c] : r_a1[c] - w_j[c];
        end
        r_m1   <= i_cmd.mask;
        r_all1 <= i_cmd.all;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.eval;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_a2[c] <= r_a1[c];
            r_b2[c] <= r_t[c] - r_a1[c];
            r_a3[c] <= r_a2[c];
            r_b3[c] <= r_b2[c];
            r_pa[c] <= r_a2[c] * r_a2[c];
            r_pb[c] <= r_b2[c] * r_b2[c];
            r_a4[c] <= r_a3[c];
            r_b4[c] <= r_b3[c];
            r_a5[c] <= r_a4[c];
            r_b5[c] <= r_b4[c];
        end
        r_ma <= MW'(r_pa[0]) - MW'(r_pa[1]) - MW'(r_pa[2]) - MW'(r_pa[3]);
        r_mb <= MW'(r_pb[0]) - MW'(r_pb[1]) - MW'(r_pb[2]) - MW'(r_pb[3]);
        r_v  <= r_ma + r_mb;
        r_m2 <= r_m1;  r_m3 <= r_m2;  r_m4 <= r_m3;  r_m5 <= r_m4;
        r_all2 <= r_all1;  r_all3 <= r_all2;  r_all4 <= r_all3;  r_all5 <= r_all4;
    end

    // the opening candidate (every jet but jet 0 in A) wins ties; otherwise lower mask wins
    assign w_better = !r_bvld || (r_v < r_bv) ||
                      ((r_v == r_bv) && (r_all5 || (!r_ball && (r_m5 < r_bm))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_bvld <= 1'b0;
        end else if (r_v5 && w_better) begin
            r_bvld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v5 && w_better) begin
            r_bv   <= r_v;
            r_bm   <= r_m5;
            r_ball <= r_all5;
            for (int c = 0; c < 4; c++) begin
                r_ba[c] <= r_a5[c];
                r_bb[c] <= r_b5[c];
            end
        end
    end

    assign o_stat.count   = r_count;
    assign o_group_mask   = mjp_pkg::fit_mask(r_bm);
    assign o_min_mass_sum = mjp_pkg::fit_mass(r_bv);
    assign o_sum_a_energy = mjp_pkg::fit_sum(r_ba[0]);
    assign o_sum_a_x      = mjp_pkg::fit_sum(r_ba[1]);
    assign o_sum_a_y      = mjp_pkg::fit_sum(r_ba[2]);
    assign o_sum_a_z      = mjp_pkg::fit_sum(r_ba[3]);
    assign o_sum_b_energy = mjp_pkg::fit_sum(r_bb[0]);
    assign o_sum_b_x      = mjp_pkg::fit_sum(r_bb[1]);
    assign o_sum_b_y      = mjp_pkg::fit_sum(r_bb[2]);
    assign o_sum_b_z      = mjp_pkg::fit_sum(r_bb[3]);
    assign o_jet_count    = 5'(r_count);
    assign o_dropped      = r_ovf;

endmodule

// ===== src/megajet_min_mass_partition.sv =====
// Megajet partition search.
// Input: one jet per transfer (start high while busy low). Items with last_jet low
// are taken while busy stays low (stored if has_jet is high), so jets may stream
// every cycle. The last_jet item closes the event: busy rises and the block,
// for n >= 2 kept jets, walks the splits in Gray-code order, one split per cycle,
// moving one jet in or out of group A each step; for fewer jets one split is scored.
// Each split's squared masses go through a five-stage pipe (B = total - A, eight
// squares, two masses, sum, compare). States after the closing transfer: init, walk
// (single for fewer jets), drain, then done, which gives the result strobe.
// Result: o_valid is high for exactly one cycle with all result fields; it is
// taken in that cycle, the receiver cannot stall. Busy falls in the next cycle
// and the jet store is empty for the next event.
// Jets beyond MAX_JETS are dropped and reported in o_dropped.
// Reset (synchronous, active low) empties the store and returns to idle.
module megajet_min_mass_partition (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [18:0]         i_energy,
    input  logic signed [19:0]  i_mom_x,
    input  logic signed [19:0]  i_mom_y,
    input  logic signed [19:0]  i_mom_z,
    input  logic                i_has_jet,
    input  logic                i_last_jet,
    output logic                o_busy,
    output logic                o_valid,
    output logic [15:0]         o_group_mask,
    output logic [50:0]         o_min_mass_sum,
    output logic [23:0]         o_sum_a_energy,
    output logic [23:0]         o_sum_a_x,
    output logic [23:0]         o_sum_a_y,
    output logic [23:0]         o_sum_a_z,
    output logic [23:0]         o_sum_b_energy,
    output logic [23:0]         o_sum_b_x,
    output logic [23:0]         o_sum_b_y,
    output logic [23:0]         o_sum_b_z,
    output logic [4:0]          o_jet_count,
    output logic                o_dropped
);

    mjp_pkg::t_cmd  w_cmd;
    mjp_pkg::t_stat w_stat;

    mjp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_last_jet (i_last_jet),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (o_busy)
    );

    mjp_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_energy       (i_energy),
        .i_mom_x        (i_mom_x),
        .i_mom_y        (i_mom_y),
        .i_mom_z        (i_mom_z),
        .i_has_jet      (i_has_jet),
        .o_stat         (w_stat),
        .o_group_mask   (o_group_mask),
        .o_min_mass_sum (o_min_mass_sum),
        .o_sum_a_energy (o_sum_a_energy),
        .o_sum_a_x      (o_sum_a_x),
        .o_sum_a_y      (o_sum_a_y),
        .o_sum_a_z      (o_sum_a_z),
        .o_sum_b_energy (o_sum_b_energy),
        .o_sum_b_x      (o_sum_b_x),
        .o_sum_b_y      (o_sum_b_y),
        .o_sum_b_z      (o_sum_b_z),
        .o_jet_count    (o_jet_count),
        .o_dropped      (o_dropped)
    );

    assign o_valid = w_cmd.emit;

endmodule

// ===== src/mjp_props.sv =====
module mjp_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        i_last_jet,
    input logic        o_busy,
    input logic        o_valid,
    input logic [15:0] o_group_mask,
    input logic [4:0]  o_jet_count
);

    // one strobe per event
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("result outside a search");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_jet_count <= 5'(mjp_pkg::MAX_JETS)))
        else $error("jet count above capacity");

    a_small_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_jet_count < 5'd2)) |-> (o_group_mask == 16'd0))
        else $error("split reported for fewer than two jets");

    a_stream_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_last_jet) |=> !o_busy)
        else $error("busy after a mid-event transfer");

endmodule

bind megajet_min_mass_partition mjp_props u_props (.*);

// ===== sim/testbench.sv =====
module testbench;

    typedef struct packed {
        logic [15:0] mask;
        logic [50:0] mass;
        logic [23:0] ae, ax, ay, az;
        logic [23:0] be, bx, by, bz;
        logic [4:0]  count;
        logic        drop;
    } t_partition;

    // Predicts the best split of each event and holds the splits still owed.
    class partition_board;
        logic [18:0]        jet_e[mjp_pkg::MAX_JETS];
        logic signed [19:0] jet_x[mjp_pkg::MAX_JETS];
        logic signed [19:0] jet_y[mjp_pkg::MAX_JETS];
        logic signed [19:0] jet_z[mjp_pkg::MAX_JETS];
        int                 kept;
        bit                 overflow;
        t_partition         owed[$];
        int                 errors;

        function void note(logic [18:0] e, logic signed [19:0] x, logic signed [19:0] y,
                           logic signed [19:0] z, bit has_jet, bit last_jet);
            if (has_jet) begin
                if (kept < mjp_pkg::MAX_JETS) begin
                    jet_e[kept] = e;
                    jet_x[kept] = x;
                    jet_y[kept] = y;
                    jet_z[kept] = z;
                    kept++;
                end else begin
                    overflow = 1;
                end
            end
            if (last_jet) begin
                owed.insert(owed.size(), best_split());
                kept = 0;
                overflow = 0;
            end
        endfunction

        function t_partition best_split();
            longint sa_e[], sa_x[], sa_y[], sa_z[];
            longint te, tx, ty, tz, v, best_val, ae, ax, ay, az, be, bx, by, bz;
            int all, best, lb, m;
            t_partition r;
            all = (1 << kept) - 1;
            sa_e = new[all + 1];
            sa_x = new[all + 1];
            sa_y = new[all + 1];
            sa_z = new[all + 1];
            sa_e[0] = 0; sa_x[0] = 0; sa_y[0] = 0; sa_z[0] = 0;
            // group A sums built from the mask with its lowest bit cleared
            for (m = 1; m <= all; m++) begin
                lb = 0;
                while (!m[lb]) lb++;
                sa_e[m] = sa_e[m & (m - 1)] + longint'(jet_e[lb]);
                sa_x[m] = sa_x[m & (m - 1)] + longint'(jet_x[lb]);
                sa_y[m] = sa_y[m & (m - 1)] + longint'(jet_y[lb]);
                sa_z[m] = sa_z[m & (m - 1)] + longint'(jet_z[lb]);
            end
            te = sa_e[all]; tx = sa_x[all]; ty = sa_y[all]; tz = sa_z[all];
            best = (kept < 2) ? 0 : all - 1;
            best_val = 0;
            for (m = best; m <= best + 1; m++) begin
                if (m == best) begin
                    ae = sa_e[m]; ax = sa_x[m]; ay = sa_y[m]; az = sa_z[m];
                    be = te - ae; bx = tx - ax; by = ty - ay; bz = tz - az;
                    best_val = ae*ae - ax*ax - ay*ay - az*az + be*be - bx*bx - by*by - bz*bz;
                end
            end
            if (kept >= 2) begin
                for (m = 1; m < all; m++) begin
                    ae = sa_e[m]; ax = sa_x[m]; ay = sa_y[m]; az = sa_z[m];
                    be = te - ae; bx = tx - ax; by = ty - ay; bz = tz - az;
                    v = ae*ae - ax*ax - ay*ay - az*az + be*be - bx*bx - by*by - bz*bz;
                    if (v < best_val) begin
                        best_val = v;
                        best = m;
                    end
                end
            end
            ae = sa_e[best]; ax = sa_x[best]; ay = sa_y[best]; az = sa_z[best];
            r.mask = best[15:0];
            r.mass = best_val[50:0];
            r.ae = ae[23:0]; r.ax = ax[23:0]; r.ay = ay[23:0]; r.az = az[23:0];
            be = te - ae; bx = tx - ax; by = ty - ay; bz = tz - az;
            r.be = be[23:0]; r.bx = bx[23:0]; r.by = by[23:0]; r.bz = bz[23:0];
            r.count = kept[4:0];
            r.drop = overflow;
            return r;
        endfunction

        function void check(t_partition got);
            t_partition want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: mask %h", got.mask);
                return;
            end
            want = owed.pop_front();
            if (want != got) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp mask %h mass %h A %h %h %h %h B %h %h %h %h n %0d d %0d",
                             want.mask, want.mass, want.ae, want.ax, want.ay, want.az,
                             want.be, want.bx, want.by, want.bz, want.count, want.drop);
                    $display("          act mask %h mass %h A %h %h %h %h B %h %h %h %h n %0d d %0d",
                             got.mask, got.mass, got.ae, got.ax, got.ay, got.az,
                             got.be, got.bx, got.by, got.bz, got.count, got.drop);
                end
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_start = 0;
    logic [18:0]        i_energy = 0;
    logic signed [19:0] i_mom_x = 0;
    logic signed [19:0] i_mom_y = 0;
    logic signed [19:0] i_mom_z = 0;
    logic               i_has_jet = 0;
    logic               i_last_jet = 0;
    logic               o_busy, o_valid, o_dropped;
    logic [15:0]        o_group_mask;
    logic [50:0]        o_min_mass_sum;
    logic [23:0]        o_sum_a_energy, o_sum_a_x, o_sum_a_y, o_sum_a_z;
    logic [23:0]        o_sum_b_energy, o_sum_b_x, o_sum_b_y, o_sum_b_z;
    logic [4:0]         o_jet_count;

    partition_board board = new();
    bit                 no_gaps;

    megajet_min_mass_partition uut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    initial begin
        #40_000_000;
        $display("megajet_min_mass_partition verification failed");
        $finish;
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check({o_group_mask, o_min_mass_sum, o_sum_a_energy, o_sum_a_x, o_sum_a_y,
                         o_sum_a_z, o_sum_b_energy, o_sum_b_x, o_sum_b_y, o_sum_b_z,
                         o_jet_count, o_dropped});
    end

    // Called at a rising edge; returns at the edge that ends the transfer plus any gap.
    task automatic send(logic [18:0] e, logic [19:0] x, logic [19:0] y, logic [19:0] z,
                        bit has_jet, bit last_jet);
        int gap;
        i_start    <= 1;
        i_energy   <= e;
        i_mom_x    <= x;
        i_mom_y    <= y;
        i_mom_z    <= z;
        i_has_jet  <= has_jet;
        i_last_jet <= last_jet;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        board.note(e, x, y, z, has_jet, last_jet);
        @(posedge i_clk);
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_start <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_jet(bit last_jet);
        logic [19:0] x, y, z;
        logic [18:0] e;
        case ($urandom_range(0, 3))
            0: begin
                e = 19'($urandom); x = 20'($urandom); y = 20'($urandom); z = 20'($urandom);
            end
            1: begin
                e = $urandom_range(0, 1) ? 19'h7ffff : 19'h00000;
                x = $urandom_range(0, 1) ? 20'h7ffff : 20'h80000;
                y = $urandom_range(0, 1) ? 20'h7ffff : 20'h80000;
                z = $urandom_range(0, 1) ? 20'h7ffff : 20'h00000;
            end
            default: begin
                // physical-ish jets: energy near momentum size
                x = 20'($urandom_range(0, 8191)) - 20'd4096;
                y = 20'($urandom_range(0, 8191)) - 20'd4096;
                z = 20'($urandom_range(0, 8191)) - 20'd4096;
                e = 19'($urandom_range(0, 16383));
            end
        endcase
        send(e, x, y, z, 1, last_jet);
    endtask

    task automatic send_event(int n, bit marker_close);
        for (int k = 0; k < n; k++)
            send_random_jet(!marker_close && k == n - 1);
        if (marker_close || n == 0)
            send(19'($urandom), 20'($urandom), 20'($urandom), 20'($urandom), 0, 1);
    endtask

    initial begin
        int jets, n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty event, single max jet, extremes, ties, noise item
        send(19'h7ffff, 20'h7ffff, 20'h7ffff, 20'h7ffff, 0, 1);
        send(19'h7ffff, 20'h80000, 20'h80000, 20'h80000, 1, 1);
        send(19'h7ffff, 20'h7ffff, 20'h80000, 20'h00000, 1, 0);
        send(19'h00000, 20'h80000, 20'h7ffff, 20'hfffff, 1, 1);
        send(19'h12345, 20'h00000, 20'h00000, 20'h00000, 0, 0);
        for (int k = 0; k < 4; k++) send(19'h0, 20'h0, 20'h0, 20'h0, 1, k == 3);
        send(19'h40000, 20'h10000, 20'hf0000, 20'h00100, 1, 0);
        send(19'h20000, 20'hfff00, 20'h00040, 20'h7ffff, 1, 0);
        send(19'h00001, 20'h00001, 20'hfffff, 20'h80000, 1, 0);
        send(19'h55555, 20'haaaaa, 20'h55555, 20'haaaaa, 0, 1);
        send(19'h2aaaa, 20'h55555, 20'haaaaa, 20'h55555, 1, 1);

        // a full store plus overflow jets, closed by a marker
        send_event(mjp_pkg::MAX_JETS + 2, 1);

        jets = 0;
        while (jets < 1850) begin
            no_gaps = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 199))
                0:       n = $urandom_range(13, mjp_pkg::MAX_JETS + 3);
                1, 2, 3: n = $urandom_range(7, 10);
                default: n = $urandom_range(0, 6);
            endcase
            if ($urandom_range(0, 9) == 0)
                send(19'($urandom), 20'($urandom), 20'($urandom), 20'($urandom), 0, 0);
            send_event(n, $urandom_range(0, 3) == 0);
            jets += (n == 0) ? 1 : n;
        end
        i_start <= 0;

        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0)
            $display("megajet_min_mass_partition verification clean");
        else
            $display("megajet_min_mass_partition verification failed");
        $finish;
    end
endmodule
